// ===== design/gps_pkg.sv =====
// Shared types and constants for the grid path search unit.
package gps_pkg;

    localparam int COORD_W    = 5;
    localparam int CFG_W      = 6;
    localparam int F_W        = 7;
    localparam int G_W        = 6;
    localparam int ADDR_W     = 4;
    localparam int COORD_SPAN = 32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    // direction a cell was entered by
    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_NX = 2'd1;
    localparam logic [1:0] DIR_PY = 2'd2;
    localparam logic [1:0] DIR_NY = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               passable;
        logic               enemy_here;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
    } req_t;

    typedef struct packed {
        logic [COORD_W-1:0] step_x;
        logic [COORD_W-1:0] step_y;
        logic               found;
        logic               last;
    } rsp_t;

    // write controls for the per-cell stores
    typedef struct packed {
        logic map_we;
        logic map_bit;
        logic seen_we;
        logic seen_bit;
        logic par_we;
    } cell_op_t;

    // open-list scan status
    typedef struct packed {
        logic done;
        logic have;
    } scan_sts_t;

endpackage

// ===== design/grid_path_search_unit.sv =====
// Top level: four-neighbour least-cost grid path search with its sequencer.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------
//  req     | in        | req_valid / req_stall | gps_pkg::req_t load/search
//  rsp     | out       | rsp_valid / rsp_stall | gps_pkg::rsp_t path cell
//  apb     | in        | psel / penable        | grid size and move limit
//
// After reset every map cell is swept clear; req_stall is high then.
// A load writes one map cell. A search clears the seen marks, then each
// expansion scans the open list and tries the four neighbours in turn.
// The walk back writes each path cell in S_BRD and steps in S_BWR; each
// result is read in S_ERD and sent from S_ELD.
// A stalled result holds in the output register; the sequencer waits behind it.
module grid_path_search_unit #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32,
    parameter int PATH_DEPTH  = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  gps_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output gps_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gps_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CW         = $clog2(MAX_COLUMNS);
    localparam int RW         = $clog2(MAX_ROWS);
    localparam int AW         = CW + RW;
    localparam int COL_CAP    = MAX_COLUMNS < gps_pkg::COORD_SPAN ?
                                MAX_COLUMNS : gps_pkg::COORD_SPAN;
    localparam int ROW_CAP    = MAX_ROWS < gps_pkg::COORD_SPAN ?
                                MAX_ROWS : gps_pkg::COORD_SPAN;
    localparam int LIST_DEPTH = COL_CAP * ROW_CAP;
    localparam int LIW        = $clog2(LIST_DEPTH);
    localparam int PW         = $clog2(PATH_DEPTH);
    localparam int EW         = 1 + gps_pkg::F_W + gps_pkg::G_W + AW;
    localparam int CDW        = gps_pkg::COORD_W;
    localparam int GW         = gps_pkg::G_W;
    localparam int FW         = gps_pkg::F_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_SGO   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_PICK  = 4'd6;
    localparam logic [3:0] S_NBR   = 4'd7;
    localparam logic [3:0] S_NCHK  = 4'd8;
    localparam logic [3:0] S_BRD   = 4'd9;
    localparam logic [3:0] S_BWR   = 4'd10;
    localparam logic [3:0] S_ERD   = 4'd11;
    localparam logic [3:0] S_ELD   = 4'd12;
    localparam logic [3:0] S_FAIL  = 4'd13;

    function automatic logic [AW-1:0] cell_addr(input logic [CDW-1:0] x,
                                                input logic [CDW-1:0] y);
        logic [5:0] x6;
        logic [5:0] y6;
        x6 = 6'(x);
        y6 = 6'(y);
        return {y6[RW-1:0], x6[CW-1:0]};
    endfunction

    function automatic logic [CDW-1:0] abs_diff(input logic [CDW-1:0] a,
                                                input logic [CDW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    logic [3:0]       state_reg;
    logic [AW-1:0]    clr_reg;
    logic [5:0]       cols_cfg_reg, rows_cfg_reg, lim_cfg_reg;
    logic [5:0]       cols_e_reg, rows_e_reg, lim_e_reg;
    logic [CDW-1:0]   sx_reg, sy_reg, gx_reg, gy_reg;
    logic [CDW-1:0]   cx_reg, cy_reg, nx_reg, ny_reg;
    logic [GW-1:0]    cg_reg;
    logic [1:0]       dir_reg;
    logic [LIW:0]     count_reg;
    logic [PW:0]      k_reg, len_reg;
    logic [PW-1:0]    e_reg;
    logic [2*CDW-1:0] path_mem [PATH_DEPTH];
    logic [2*CDW-1:0] path_rd_reg;
    logic             rsp_valid_reg;
    gps_pkg::rsp_t    rsp_reg;

    logic [5:0]       cols_eff, rows_eff, lim_eff;
    logic             req_accept, cfg_write, start_bad, load_in_range, slot_free;
    logic [AW-1:0]    addr_mux, goal_addr, start_addr, n_addr;
    gps_pkg::cell_op_t cop;
    logic [1:0]       par_wdata;
    logic             enter_rd, seen_rd;
    logic [1:0]       par_rd;
    logic [CDW-1:0]   hx, hy;
    logic [FW-1:0]    hg, f_new;
    logic [5:0]       nbx, nby;
    logic             nb_ok, ins_ok;
    logic             l_we;
    logic [LIW-1:0]   l_waddr;
    logic [EW-1:0]    l_wdata, best;
    logic [LIW-1:0]   best_idx;
    gps_pkg::scan_sts_t sts;
    logic [AW-1:0]    b_addr;
    logic [GW-1:0]    b_g;
    logic [5:0]       bx6, by6;
    logic [FW-1:0]    len_new;
    logic [PW:0]      k_dec;
    logic             e_last;

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != S_IDLE);
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;

    // effective map size and cost limit
    always_comb
    begin
        if (cols_cfg_reg == 6'd0)
            cols_eff = 6'd1;
        else if ({1'b0, cols_cfg_reg} > 7'(COL_CAP))
            cols_eff = 6'(COL_CAP);
        else
            cols_eff = cols_cfg_reg;
        if (rows_cfg_reg == 6'd0)
            rows_eff = 6'd1;
        else if ({1'b0, rows_cfg_reg} > 7'(ROW_CAP))
            rows_eff = 6'(ROW_CAP);
        else
            rows_eff = rows_cfg_reg;
        if ({1'b0, lim_cfg_reg} > 7'(PATH_DEPTH - 1))
            lim_eff = 6'(PATH_DEPTH - 1);
        else
            lim_eff = lim_cfg_reg;
    end

    assign start_bad = ({1'b0, req.cell_x} >= cols_eff) || ({1'b0, req.cell_y} >= rows_eff) ||
                       ({1'b0, req.goal_x} >= cols_eff) || ({1'b0, req.goal_y} >= rows_eff);
    assign load_in_range = ({2'b00, req.cell_x} < 7'(MAX_COLUMNS)) &&
                           ({2'b00, req.cell_y} < 7'(MAX_ROWS));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 6'd32;
            rows_cfg_reg <= 6'd32;
            lim_cfg_reg  <= 6'd63;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                gps_pkg::REG_COLUMNS: cols_cfg_reg <= pwdata[5:0];
                gps_pkg::REG_ROWS:    rows_cfg_reg <= pwdata[5:0];
                gps_pkg::REG_LIMIT:   lim_cfg_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            gps_pkg::REG_COLUMNS: prdata = {26'd0, cols_cfg_reg};
            gps_pkg::REG_ROWS:    prdata = {26'd0, rows_cfg_reg};
            gps_pkg::REG_LIMIT:   prdata = {26'd0, lim_cfg_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // neighbour in the current direction
    always_comb
    begin
        nbx   = {1'b0, cx_reg};
        nby   = {1'b0, cy_reg};
        nb_ok = 1'b1;
        unique case (dir_reg)
            gps_pkg::DIR_PX: nbx = {1'b0, cx_reg} + 6'd1;
            gps_pkg::DIR_NX:
            begin
                nbx   = {1'b0, cx_reg} - 6'd1;
                nb_ok = (cx_reg != '0);
            end
            gps_pkg::DIR_PY: nby = {1'b0, cy_reg} + 6'd1;
            default:
            begin
                nby   = {1'b0, cy_reg} - 6'd1;
                nb_ok = (cy_reg != '0);
            end
        endcase
        ins_ok = (7'(cg_reg) + 7'd1) <= 7'(lim_e_reg);
        nb_ok  = nb_ok && (nbx < cols_e_reg) && (nby < rows_e_reg) && ins_ok;
    end

    assign start_addr = cell_addr(sx_reg, sy_reg);
    assign goal_addr  = cell_addr(gx_reg, gy_reg);
    assign n_addr     = cell_addr(nx_reg, ny_reg);

    // score unit: cost plus Manhattan distance to goal
    assign hx    = (state_reg == S_START) ? sx_reg : nx_reg;
    assign hy    = (state_reg == S_START) ? sy_reg : ny_reg;
    assign hg    = (state_reg == S_START) ? '0 : 7'(cg_reg) + 7'd1;
    assign f_new = hg + 7'(abs_diff(hx, gx_reg)) + 7'(abs_diff(hy, gy_reg));

    // best entry fields
    assign b_addr  = best[AW-1:0];
    assign b_g     = best[AW +: GW];
    assign bx6     = 6'(b_addr[CW-1:0]);
    assign by6     = 6'(b_addr[AW-1:CW]);
    assign len_new = 7'(b_g) + 7'd1;
    assign k_dec   = k_reg - 1'b1;
    assign e_last  = ({1'b0, e_reg} + 1'b1) == len_reg;

    // cell store address and writes
    always_comb
    begin
        cop       = '0;
        par_wdata = dir_reg;
        unique case (state_reg) inside
            S_INIT, S_CLR: addr_mux = clr_reg;
            S_START:       addr_mux = start_addr;
            S_NBR:         addr_mux = cell_addr(nbx[CDW-1:0], nby[CDW-1:0]);
            S_NCHK:        addr_mux = n_addr;
            S_BRD:         addr_mux = cell_addr(cx_reg, cy_reg);
            default:       addr_mux = cell_addr(req.cell_x, req.cell_y);
        endcase
        unique case (state_reg) inside
            S_INIT:
            begin
                cop.map_we  = 1'b1;
                cop.seen_we = 1'b1;
            end
            S_CLR: cop.seen_we = 1'b1;
            S_IDLE:
            begin
                cop.map_we  = req_accept && (req.cmd == gps_pkg::CMD_LOAD) && load_in_range;
                cop.map_bit = req.passable && !req.enemy_here;
            end
            S_START:
            begin
                cop.seen_we  = 1'b1;
                cop.seen_bit = 1'b1;
                cop.par_we   = 1'b1;
                par_wdata    = gps_pkg::DIR_PX;
            end
            S_NCHK:
            begin
                cop.seen_we  = enter_rd && !seen_rd;
                cop.seen_bit = 1'b1;
                cop.par_we   = enter_rd && !seen_rd;
            end
            default: ;
        endcase
    end

    // open-list writes: seed, insert, close
    always_comb
    begin
        l_we    = 1'b0;
        l_waddr = count_reg[LIW-1:0];
        l_wdata = {1'b0, f_new, 6'(hg), n_addr};
        unique case (state_reg) inside
            S_START:
            begin
                l_we    = 1'b1;
                l_waddr = '0;
                l_wdata = {1'b0, f_new, {GW{1'b0}}, start_addr};
            end
            S_NCHK: l_we = enter_rd && !seen_rd;
            S_PICK:
            begin
                l_we    = sts.have && (b_addr != goal_addr);
                l_waddr = best_idx;
                l_wdata = {1'b1, best[EW-2:0]};
            end
            default: ;
        endcase
    end

    gps_cell #(.AW(AW)) u_cell (
        .clk       (clk),
        .op        (cop),
        .addr      (addr_mux),
        .par_wdata (par_wdata),
        .enter_rd  (enter_rd),
        .seen_rd   (seen_rd),
        .par_rd    (par_rd)
    );

    gps_list #(.AW(AW), .LIW(LIW)) u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_go  (state_reg == S_SGO),
        .count    (count_reg),
        .we       (l_we),
        .waddr    (l_waddr),
        .wdata    (l_wdata),
        .sts      (sts),
        .best     (best),
        .best_idx (best_idx)
    );

    // path buffer, filled goal first and read start first
    always_ff @(posedge clk)
    begin
        if (state_reg == S_BRD)
        begin
            path_mem[k_dec[PW-1:0]] <= {cy_reg, cx_reg};
        end
        if (state_reg == S_ERD)
        begin
            path_rd_reg <= path_mem[e_reg];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            count_reg     <= '0;
            dir_reg       <= gps_pkg::DIR_PX;
            k_reg         <= '0;
            len_reg       <= '0;
            e_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            cg_reg        <= '0;
            cols_e_reg    <= '0;
            rows_e_reg    <= '0;
            lim_e_reg     <= '0;
        end
        else
        begin
            if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_accept && (req.cmd == gps_pkg::CMD_SEARCH))
                    begin
                        sx_reg     <= req.cell_x;
                        sy_reg     <= req.cell_y;
                        gx_reg     <= req.goal_x;
                        gy_reg     <= req.goal_y;
                        cols_e_reg <= cols_eff;
                        rows_e_reg <= rows_eff;
                        lim_e_reg  <= lim_eff;
                        clr_reg    <= '0;
                        state_reg  <= start_bad ? S_FAIL : S_CLR;
                    end
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                        state_reg <= S_START;
                end
                S_START:
                begin
                    count_reg <= (LIW+1)'(1);
                    state_reg <= S_SGO;
                end
                S_SGO: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (sts.done)
                        state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    if (!sts.have)
                        state_reg <= S_FAIL;
                    else if (b_addr == goal_addr)
                    begin
                        len_reg   <= (PW+1)'(len_new);
                        k_reg     <= (PW+1)'(len_new);
                        cx_reg    <= gx_reg;
                        cy_reg    <= gy_reg;
                        state_reg <= S_BRD;
                    end
                    else
                    begin
                        cx_reg    <= bx6[CDW-1:0];
                        cy_reg    <= by6[CDW-1:0];
                        cg_reg    <= b_g;
                        dir_reg   <= gps_pkg::DIR_PX;
                        state_reg <= S_NBR;
                    end
                end
                S_NBR:
                begin
                    if (nb_ok)
                    begin
                        nx_reg    <= nbx[CDW-1:0];
                        ny_reg    <= nby[CDW-1:0];
                        state_reg <= S_NCHK;
                    end
                    else if (dir_reg == gps_pkg::DIR_NY)
                        state_reg <= S_SGO;
                    else
                        dir_reg <= dir_reg + 1'b1;
                end
                S_NCHK:
                begin
                    if (enter_rd && !seen_rd)
                        count_reg <= count_reg + 1'b1;
                    if (dir_reg == gps_pkg::DIR_NY)
                        state_reg <= S_SGO;
                    else
                    begin
                        dir_reg   <= dir_reg + 1'b1;
                        state_reg <= S_NBR;
                    end
                end
                S_BRD: state_reg <= S_BWR;
                S_BWR:
                begin
                    // step back against the entry direction
                    case (par_rd)
                        gps_pkg::DIR_PX:
                            if (cx_reg != '0) cx_reg <= cx_reg - 1'b1;
                        gps_pkg::DIR_NX:
                            if ((7'(cx_reg) + 7'd1) < 7'(MAX_COLUMNS)) cx_reg <= cx_reg + 1'b1;
                        gps_pkg::DIR_PY:
                            if (cy_reg != '0) cy_reg <= cy_reg - 1'b1;
                        default:
                            if ((7'(cy_reg) + 7'd1) < 7'(MAX_ROWS)) cy_reg <= cy_reg + 1'b1;
                    endcase
                    k_reg <= k_dec;
                    if (k_dec == '0)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                        state_reg <= S_BRD;
                end
                S_ERD: state_reg <= S_ELD;
                S_ELD:
                begin
                    if (slot_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_reg.step_x <= path_rd_reg[CDW-1:0];
                        rsp_reg.step_y <= path_rd_reg[2*CDW-1:CDW];
                        rsp_reg.found  <= 1'b1;
                        rsp_reg.last   <= e_last;
                        if (e_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            e_reg     <= e_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                S_FAIL:
                begin
                    if (slot_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_reg.step_x <= '0;
                        rsp_reg.step_y <= '0;
                        rsp_reg.found  <= 1'b0;
                        rsp_reg.last   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a failure word is always a lone, zeroed final word
    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.last && rsp.step_x == '0 && rsp.step_y == '0)
        else $error("failure word malformed");

    // the open list never outgrows the reachable cells
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (LIW+1)'(LIST_DEPTH))
        else $error("open list overflow");

    // every selected open cell respects the cost limit
    a_pick_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PICK && sts.have |-> b_g <= lim_e_reg)
        else $error("selected cell over cost limit");

    // a path is never longer than the buffer
    a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BRD |-> k_reg != '0 && k_reg <= (PW+1)'(PATH_DEPTH))
        else $error("path length out of range");

endmodule

// ===== design/gps_cell.sv =====
// Per-cell stores: enterable bit, seen bit and entry direction.
module gps_cell #(
    parameter int AW = 10
) (
    input  logic             clk,
    input  gps_pkg::cell_op_t op,
    input  logic [AW-1:0]    addr,
    input  logic [1:0]       par_wdata,
    output logic             enter_rd,
    output logic             seen_rd,
    output logic [1:0]       par_rd
);

    logic       enter_mem [2**AW];
    logic       seen_mem  [2**AW];
    logic [1:0] par_mem   [2**AW];

    // enterable map: passable and free of enemies
    always_ff @(posedge clk)
    begin
        if (op.map_we)
        begin
            enter_mem[addr] <= op.map_bit;
        end
        enter_rd <= enter_mem[addr];
    end

    // open-or-closed mark, cleared before each search
    always_ff @(posedge clk)
    begin
        if (op.seen_we)
        begin
            seen_mem[addr] <= op.seen_bit;
        end
        seen_rd <= seen_mem[addr];
    end

    // entry direction for the walk back
    always_ff @(posedge clk)
    begin
        if (op.par_we)
        begin
            par_mem[addr] <= par_wdata;
        end
        par_rd <= par_mem[addr];
    end

endmodule

// ===== design/gps_list.sv =====
// Open list in insertion order with its least-score scan unit.
module gps_list #(
    parameter int AW  = 10,
    parameter int LIW = 10
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        scan_go,
    input  logic [LIW:0]                                count,
    input  logic                                        we,
    input  logic [LIW-1:0]                              waddr,
    input  logic [gps_pkg::F_W+gps_pkg::G_W+AW:0]       wdata,
    output gps_pkg::scan_sts_t                          sts,
    output logic [gps_pkg::F_W+gps_pkg::G_W+AW:0]       best,
    output logic [LIW-1:0]                              best_idx
);

    localparam int EW   = 1 + gps_pkg::F_W + gps_pkg::G_W + AW;
    localparam int FLSB = gps_pkg::G_W + AW;

    logic [EW-1:0]  mem [2**LIW];
    logic [EW-1:0]  rdata_reg;
    logic [LIW:0]   idx_reg;
    logic [LIW-1:0] pidx_reg;
    logic [EW-1:0]  best_reg;
    logic [LIW-1:0] bidx_reg;
    logic           scanning_reg;
    logic           pend_reg;
    logic           done_reg;
    logic           have_reg;
    logic           rd_en;
    logic           better;

    assign rd_en  = scanning_reg && !scan_go && (idx_reg < count);
    // strict less-than keeps the earliest inserted on a tie
    assign better = !rdata_reg[EW-1] &&
                    (!have_reg || (rdata_reg[FLSB +: gps_pkg::F_W] <
                                   best_reg[FLSB +: gps_pkg::F_W]));

    // entry storage, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[idx_reg[LIW-1:0]];
        end
    end

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            have_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (scan_go)
            begin
                scanning_reg <= 1'b1;
                pend_reg     <= 1'b0;
                have_reg     <= 1'b0;
                idx_reg      <= '0;
            end
            else if (scanning_reg)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (pend_reg && better)
                begin
                    have_reg <= 1'b1;
                end
                if (!rd_en && !pend_reg)
                begin
                    scanning_reg <= 1'b0;
                    done_reg     <= 1'b1;
                end
            end
        end
    end

    // best entry so far
    always_ff @(posedge clk)
    begin
        pidx_reg <= idx_reg[LIW-1:0];
        if (scanning_reg && pend_reg && better)
        begin
            best_reg <= rdata_reg;
            bidx_reg <= pidx_reg;
        end
    end

    assign sts.done = done_reg;
    assign sts.have = have_reg;
    assign best     = best_reg;
    assign best_idx = bidx_reg;

endmodule
